@@ rtl/cpp_pkg.sv @@
// Shared types and constants for the cylinder particle pushout block.
// Holds the item structs, the push kind and register index codes, and the datapath widths.
`default_nettype none

package cpp_pkg;

    // Fixed-point formats.
    localparam int COORD_WIDTH    = 24;
    localparam int AXIS_FRAC_BITS = 14;
    localparam int AXIS_W         = 16;
    localparam int CFG_W          = 3 * AXIS_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CEN_W          = 24;
    localparam int LEN_W          = 23;

    // Square root: radial components are below 2^MAG_W in magnitude when near.
    localparam int MAG_W  = 24;
    localparam int SQ_W   = 2 * MAG_W + 1;
    localparam int DIST_W = MAG_W + 1;

    // Divider: numerator, denominator and quotient widths.
    localparam int Q_W    = 26;
    localparam int DEN_W  = LEN_W + AXIS_FRAC_BITS;
    localparam int NUM_W  = 65;

    // Register reset values: unit axes X, Y and Z.
    localparam logic [CFG_W-1:0] AXIS_X_RST = CFG_W'(1 << AXIS_FRAC_BITS);
    localparam logic [CFG_W-1:0] AXIS_Y_RST = CFG_W'(1 << AXIS_FRAC_BITS) << AXIS_W;
    localparam logic [CFG_W-1:0] AXIS_Z_RST = CFG_W'(1 << AXIS_FRAC_BITS) << (2 * AXIS_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_X = 3'd0,
        CFG_AXIS_Y = 3'd1,
        CFG_AXIS_Z = 3'd2,
        CFG_CEN_X  = 3'd3,
        CFG_CEN_Y  = 3'd4,
        CFG_CEN_Z  = 3'd5,
        CFG_HEIGHT = 3'd6,
        CFG_RADIUS = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PUSH_NONE   = 2'd0,
        PUSH_CAP    = 2'd1,
        PUSH_RADIAL = 2'd2,
        PUSH_AXIS   = 2'd3
    } t_push_kind;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic                          pinned;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        t_push_kind                    push_kind;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/cylinder_particle_pushout.sv @@
// Top level of the cylinder particle pushout block; uses cpp_pkg, cpp_isqrt and cpp_div.
// Pushes each particle position out of a configured oriented cylinder.
`default_nettype none

// One particle enters per clock and its corrected position passes in order through five
// projection and squaring stages, a 25-stage square root for the radial distance, four
// stages of penetration and scaling arithmetic, a 26-stage divider for the radial
// push, and the output register. Throughput is one item per cycle while results are
// taken. When the output register holds a result that is not taken, the whole
// pipeline holds and input ready drops until the result leaves. Configuration
// registers are written through their own channel, which is always ready, and
// should change only when the pipeline is empty.
module cylinder_particle_pushout
    import cpp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int W        = COORD_WIDTH;
    localparam int F        = AXIS_FRAC_BITS;
    localparam int D_W      = W + 1;
    localparam int PROD_W   = D_W + AXIS_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int PROJ_W   = SUM_W - F;
    localparam int RAD_W    = MAG_W + 1;
    localparam int HP_W     = LEN_W - 1;
    localparam int RPEN_W   = DIST_W + 1;
    localparam int FA_W     = LEN_W + 1;
    localparam int FIX_P_W  = FA_W + AXIS_W;
    localparam int FIX_W    = FIX_P_W - F;
    localparam int RP_W     = RAD_W + AXIS_W;
    localparam int S_W      = RP_W + 1;
    localparam int SMAG_W   = S_W - 1;
    localparam int SLO_W    = LEN_W;
    localparam int SHI_W    = SMAG_W - SLO_W;
    localparam int DELTA_W  = Q_W + 1;
    localparam int OSUM_W   = DELTA_W + 1;
    localparam int P1_IDX   = 5 + DIST_W;
    localparam int LAT      = 5 + DIST_W + 4 + Q_W + 1;

    localparam logic signed [SUM_W-1:0]   SUM_HALF = SUM_W'(1 << (F - 1));
    localparam logic signed [FIX_P_W-1:0] FIX_HALF = FIX_P_W'(1 << (F - 1));
    localparam logic signed [PROJ_W-1:0]  RAD_HI   = PROJ_W'(1 << MAG_W);
    localparam logic signed [PROJ_W-1:0]  RAD_LO   = -RAD_HI;
    localparam logic signed [OSUM_W-1:0]  OUT_MAX  = OSUM_W'((1 << (W - 1)) - 1);
    localparam logic signed [OSUM_W-1:0]  OUT_MIN  = -OUT_MAX - OSUM_W'(1);

    typedef struct packed {
        logic [2:0][W-1:0]  pos;
        logic               ok;
        logic               ap_neg;
        logic [HP_W-1:0]    hpen;
        logic [RAD_W-1:0]   rx;
        logic [RAD_W-1:0]   rz;
    } t_sq_side;

    typedef struct packed {
        logic [2:0][W-1:0]     pos;
        t_push_kind            kind;
        logic [2:0]            sneg;
        logic [2:0][FIX_W-1:0] fix;
    } t_dv_side;

    // Configuration registers.
    logic [CFG_W-1:0] r_axis_x, r_axis_y, r_axis_z;
    logic [CEN_W-1:0] r_cen [3];
    logic [LEN_W-1:0] r_height, r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_x <= AXIS_X_RST;
            r_axis_y <= AXIS_Y_RST;
            r_axis_z <= AXIS_Z_RST;
            r_cen[0] <= '0;
            r_cen[1] <= '0;
            r_cen[2] <= '0;
            r_height <= '0;
            r_radius <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_AXIS_X: r_axis_x <= i_cfg_data;
                CFG_AXIS_Y: r_axis_y <= i_cfg_data;
                CFG_AXIS_Z: r_axis_z <= i_cfg_data;
                CFG_CEN_X:  r_cen[0] <= i_cfg_data[CEN_W-1:0];
                CFG_CEN_Y:  r_cen[1] <= i_cfg_data[CEN_W-1:0];
                CFG_CEN_Z:  r_cen[2] <= i_cfg_data[CEN_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[LEN_W-1:0];
                CFG_RADIUS: r_radius <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Axis components: row 0 radial X, row 1 cylinder axis, row 2 radial Z.
    logic signed [AXIS_W-1:0] w_axis [3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_axis[0][k] = $signed(r_axis_x[k*AXIS_W +: AXIS_W]);
            w_axis[1][k] = $signed(r_axis_y[k*AXIS_W +: AXIS_W]);
            w_axis[2][k] = $signed(r_axis_z[k*AXIS_W +: AXIS_W]);
        end
    end

    // Pipeline control: every stage moves together; valid bits shift alongside.
    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Stage 1: offset from the cylinder center.
    logic [2:0][W-1:0]      r_s1_pos;
    logic                   r_s1_pin;
    logic signed [D_W-1:0]  r_s1_d [3];
    logic signed [W-1:0]    w_pos [3];

    assign w_pos[0] = i_in_data.pos_x;
    assign w_pos[1] = i_in_data.pos_y;
    assign w_pos[2] = i_in_data.pos_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pin <= i_in_data.pinned;
            for (int k = 0; k < 3; k++) begin
                r_s1_pos[k] <= w_pos[k];
                r_s1_d[k]   <= D_W'(w_pos[k]) - D_W'($signed(r_cen[k]));
            end
        end
    end

    // Stage 2: nine component products for the three projections.
    logic [2:0][W-1:0]        r_s2_pos;
    logic                     r_s2_pin;
    logic signed [PROD_W-1:0] r_s2_p [3][3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_pos <= r_s1_pos;
            r_s2_pin <= r_s1_pin;
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_s2_p[j][k] <= PROD_W'(r_s1_d[k]) * PROD_W'(w_axis[j][k]);
                end
            end
        end
    end

    // Stage 3: sum and round each projection back to the coordinate format.
    logic [2:0][W-1:0]        r_s3_pos;
    logic                     r_s3_pin;
    logic signed [PROJ_W-1:0] r_s3_proj [3];
    logic signed [SUM_W-1:0]  w_s3_sum [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_s3_sum[j] = SUM_W'(r_s2_p[j][0]) + SUM_W'(r_s2_p[j][1])
                        + SUM_W'(r_s2_p[j][2]) + SUM_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_pos <= r_s2_pos;
            r_s3_pin <= r_s2_pin;
            for (int j = 0; j < 3; j++) begin
                r_s3_proj[j] <= PROJ_W'(w_s3_sum[j] >>> F);
            end
        end
    end

    // Stage 4: cap penetration, the near test and the radial squares.
    logic signed [PROJ_W-1:0] w_rx, w_ap, w_rz;
    logic [PROJ_W-1:0]        w_ap_abs;
    logic signed [PROJ_W:0]   w_hpen;
    logic                     w_near;
    logic [MAG_W-1:0]         w_mx, w_mz;
    logic [PROJ_W-1:0]        w_rx_abs, w_rz_abs;

    assign w_rx     = r_s3_proj[0];
    assign w_ap     = r_s3_proj[1];
    assign w_rz     = r_s3_proj[2];
    assign w_ap_abs = w_ap[PROJ_W-1] ? PROJ_W'(-w_ap) : PROJ_W'(w_ap);
    assign w_rx_abs = w_rx[PROJ_W-1] ? PROJ_W'(-w_rx) : PROJ_W'(w_rx);
    assign w_rz_abs = w_rz[PROJ_W-1] ? PROJ_W'(-w_rz) : PROJ_W'(w_rz);
    assign w_mx     = w_rx_abs[MAG_W-1:0];
    assign w_mz     = w_rz_abs[MAG_W-1:0];
    assign w_hpen   = $signed({{(PROJ_W+2-LEN_W){1'b0}}, r_height[LEN_W-1:1]})
                    - $signed({1'b0, w_ap_abs});
    assign w_near   = (w_rx < RAD_HI) && (w_rx > RAD_LO) && (w_rz < RAD_HI) && (w_rz > RAD_LO);

    t_sq_side             r_s4_sb;
    logic [2*MAG_W-1:0]   r_s4_sqx, r_s4_sqz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_sb.pos    <= r_s3_pos;
            r_s4_sb.ok     <= !r_s3_pin && (w_hpen > 0) && w_near;
            r_s4_sb.ap_neg <= w_ap[PROJ_W-1];
            r_s4_sb.hpen   <= w_hpen[HP_W-1:0];
            r_s4_sb.rx     <= w_rx[RAD_W-1:0];
            r_s4_sb.rz     <= w_rz[RAD_W-1:0];
            r_s4_sqx       <= w_mx * w_mx;
            r_s4_sqz       <= w_mz * w_mz;
        end
    end

    // Stage 5: squared radial distance.
    t_sq_side        r_s5_sb;
    logic [SQ_W-1:0] r_s5_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_sb <= r_s4_sb;
            r_s5_v  <= SQ_W'(r_s4_sqx) + SQ_W'(r_s4_sqz);
        end
    end

    // Square root, with the side data delayed to match.
    logic [DIST_W-1:0] w_dist;
    t_sq_side          r_sq_sb [DIST_W];

    cpp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_value (r_s5_v),
        .o_root  (w_dist)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_sb[0] <= r_s5_sb;
            for (int i = 1; i < DIST_W; i++) begin
                r_sq_sb[i] <= r_sq_sb[i-1];
            end
        end
    end

    // P1: radial penetration, push classification, radial vector products.
    t_sq_side                 w_p1_in;
    logic signed [RPEN_W-1:0] w_rpen;
    logic signed [FA_W-1:0]   w_hpen_ext;
    t_push_kind               w_kind;

    assign w_p1_in    = r_sq_sb[DIST_W-1];
    assign w_rpen     = $signed({{(RPEN_W-LEN_W){1'b0}}, r_radius}) - $signed({1'b0, w_dist});
    assign w_hpen_ext = $signed({{(FA_W-HP_W){1'b0}}, w_p1_in.hpen});

    always_comb begin
        w_kind = PUSH_NONE;
        if (w_p1_in.ok && (w_rpen > 0)) begin
            if ($signed({{(RPEN_W-HP_W){1'b0}}, w_p1_in.hpen}) <= w_rpen) begin
                w_kind = PUSH_CAP;
            end else if (w_dist != '0) begin
                w_kind = PUSH_RADIAL;
            end else begin
                w_kind = PUSH_AXIS;
            end
        end
    end

    logic [2:0][W-1:0]       r_p1_pos;
    t_push_kind              r_p1_kind;
    logic [LEN_W-1:0]        r_p1_rpen;
    logic [LEN_W-1:0]        r_p1_dist;
    logic signed [FA_W-1:0]  r_p1_fa;
    logic signed [RP_W-1:0]  r_p1_px [3];
    logic signed [RP_W-1:0]  r_p1_pz [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_pos  <= w_p1_in.pos;
            r_p1_kind <= w_kind;
            r_p1_rpen <= w_rpen[LEN_W-1:0];
            r_p1_dist <= w_dist[LEN_W-1:0];
            if (w_kind == PUSH_CAP) begin
                r_p1_fa <= w_p1_in.ap_neg ? -w_hpen_ext : w_hpen_ext;
            end else begin
                r_p1_fa <= w_rpen[FA_W-1:0];
            end
            for (int k = 0; k < 3; k++) begin
                r_p1_px[k] <= RP_W'($signed(w_p1_in.rx)) * RP_W'(w_axis[0][k]);
                r_p1_pz[k] <= RP_W'($signed(w_p1_in.rz)) * RP_W'(w_axis[2][k]);
            end
        end
    end

    // P2: radial vector in world space, and the cap or on-axis push product.
    logic [2:0][W-1:0]         r_p2_pos;
    t_push_kind                r_p2_kind;
    logic [LEN_W-1:0]          r_p2_rpen;
    logic [LEN_W-1:0]          r_p2_dist;
    logic signed [S_W-1:0]     r_p2_s [3];
    logic signed [FIX_P_W-1:0] r_p2_fp [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_pos  <= r_p1_pos;
            r_p2_kind <= r_p1_kind;
            r_p2_rpen <= r_p1_rpen;
            r_p2_dist <= r_p1_dist;
            for (int k = 0; k < 3; k++) begin
                r_p2_s[k]  <= S_W'(r_p1_px[k]) + S_W'(r_p1_pz[k]);
                r_p2_fp[k] <= FIX_P_W'(r_p1_fa) * FIX_P_W'((r_p1_kind == PUSH_CAP)
                                                    ? w_axis[1][k] : w_axis[0][k]);
            end
        end
    end

    // P3: split magnitude products with the penetration, and round the fixed push.
    logic [SMAG_W-1:0]        w_smag [3];
    logic signed [FIX_P_W-1:0] w_fix_sum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_smag[k]    = r_p2_s[k][S_W-1] ? SMAG_W'(-r_p2_s[k]) : SMAG_W'(r_p2_s[k]);
            w_fix_sum[k] = r_p2_fp[k] + FIX_HALF;
        end
    end

    logic [2:0][W-1:0]         r_p3_pos;
    t_push_kind                r_p3_kind;
    logic [LEN_W-1:0]          r_p3_dist;
    logic [2:0]                r_p3_sneg;
    logic [2:0][FIX_W-1:0]     r_p3_fix;
    logic [SLO_W+LEN_W-1:0]    r_p3_lo [3];
    logic [SHI_W+LEN_W-1:0]    r_p3_hi [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_pos  <= r_p2_pos;
            r_p3_kind <= r_p2_kind;
            r_p3_dist <= r_p2_dist;
            for (int k = 0; k < 3; k++) begin
                r_p3_sneg[k] <= r_p2_s[k][S_W-1];
                r_p3_fix[k]  <= FIX_W'(w_fix_sum[k] >>> F);
                r_p3_lo[k]   <= w_smag[k][SLO_W-1:0] * r_p2_rpen;
                r_p3_hi[k]   <= w_smag[k][SMAG_W-1:SLO_W] * r_p2_rpen;
            end
        end
    end

    // P4: numerator with the rounding half, and the divisor.
    t_dv_side         r_p4_sb;
    logic [NUM_W-1:0] r_p4_num [3];
    logic [DEN_W-1:0] r_p4_den;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_sb.pos  <= r_p3_pos;
            r_p4_sb.kind <= r_p3_kind;
            r_p4_sb.sneg <= r_p3_sneg;
            r_p4_sb.fix  <= r_p3_fix;
            r_p4_den     <= DEN_W'(r_p3_dist) << F;
            for (int k = 0; k < 3; k++) begin
                r_p4_num[k] <= (NUM_W'(r_p3_hi[k]) << SLO_W) + NUM_W'(r_p3_lo[k])
                             + (NUM_W'(r_p3_dist) << (F - 1));
            end
        end
    end

    // Divider lanes, with the side data delayed to match.
    logic [Q_W-1:0] w_quo [3];
    t_dv_side       r_dv_sb [Q_W];

    for (genvar gk = 0; gk < 3; gk++) begin : g_div
        cpp_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_p4_num[gk]),
            .i_den (r_p4_den),
            .o_quo (w_quo[gk])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_sb[0] <= r_p4_sb;
            for (int i = 1; i < Q_W; i++) begin
                r_dv_sb[i] <= r_dv_sb[i-1];
            end
        end
    end

    // Output: apply the push and saturate.
    t_dv_side                 w_o_in;
    logic signed [DELTA_W-1:0] w_delta [3];
    logic signed [OSUM_W-1:0]  w_osum [3];
    logic signed [W-1:0]       w_osat [3];
    t_out_item                r_out;

    assign w_o_in = r_dv_sb[Q_W-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (w_o_in.kind)
                PUSH_RADIAL: w_delta[k] = w_o_in.sneg[k] ? -$signed({1'b0, w_quo[k]})
                                                         : $signed({1'b0, w_quo[k]});
                PUSH_CAP,
                PUSH_AXIS:   w_delta[k] = DELTA_W'($signed(w_o_in.fix[k]));
                default:     w_delta[k] = '0;
            endcase
            w_osum[k] = OSUM_W'($signed(w_o_in.pos[k])) + OSUM_W'(w_delta[k]);
            if (w_osum[k] > OUT_MAX) begin
                w_osat[k] = W'(OUT_MAX);
            end else if (w_osum[k] < OUT_MIN) begin
                w_osat[k] = W'(OUT_MIN);
            end else begin
                w_osat[k] = W'(w_osum[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.out_x     <= w_osat[0];
            r_out.out_y     <= w_osat[1];
            r_out.out_z     <= w_osat[2];
            r_out.push_kind <= w_o_in.kind;
        end
    end

    assign o_out_data = r_out;

`ifndef SYNTHESIS
    // A radial push always has a nonzero distance to divide by.
    a_radial_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[P1_IDX] && (r_p1_kind == PUSH_RADIAL)) |-> (r_p1_dist != '0))
        else $error("radial push with zero distance");

    // An on-axis push only happens at zero radial distance.
    a_axis_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[P1_IDX] && (r_p1_kind == PUSH_AXIS)) |-> (r_p1_dist == '0))
        else $error("on-axis push off the axis");

    // A held pipeline keeps every valid bit in place.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");
`endif

endmodule

`default_nettype wire

@@ rtl/cpp_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on cpp_pkg for SQ_W and DIST_W.
`default_nettype none

module cpp_isqrt
    import cpp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [SQ_W-1:0]   i_value,
    output logic      [DIST_W-1:0] o_root
);

    localparam int TW = 2 * DIST_W + 1;

    logic [SQ_W-1:0]   r_rem  [DIST_W];
    logic [DIST_W-1:0] r_root [DIST_W];

    // Each stage tries the next lower root bit against the running remainder.
    for (genvar gi = 0; gi < DIST_W; gi++) begin : g_stage
        localparam int B = DIST_W - 1 - gi;
        logic [SQ_W-1:0]   w_rem_in;
        logic [DIST_W-1:0] w_root_in;
        logic [TW-1:0]     w_trial;
        logic              w_fit;

        if (gi == 0) begin : g_first
            assign w_rem_in  = i_value;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[gi-1];
            assign w_root_in = r_root[gi-1];
        end

        assign w_trial = (TW'(w_root_in) << (B + 1)) | (TW'(1) << (2 * B));
        assign w_fit   = TW'(w_rem_in) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi]  <= w_fit ? (w_rem_in - w_trial[SQ_W-1:0]) : w_rem_in;
                r_root[gi] <= w_fit ? (w_root_in | (DIST_W'(1) << B)) : w_root_in;
            end
        end
    end

    assign o_root = r_root[DIST_W-1];

endmodule

`default_nettype wire

@@ rtl/cpp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cpp_pkg for NUM_W, DEN_W and Q_W; the quotient must fit in Q_W bits.
`default_nettype none

module cpp_div
    import cpp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [Q_W-1:0]   o_quo
);

    logic [DEN_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_low [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];

    // Shift in one numerator bit per stage, subtract the divisor when it fits.
    for (genvar gi = 0; gi < Q_W; gi++) begin : g_stage
        logic [DEN_W-1:0] w_rem_in;
        logic [Q_W-1:0]   w_low_in;
        logic [Q_W-1:0]   w_quo_in;
        logic [DEN_W-1:0] w_den_in;
        logic [DEN_W:0]   w_trial;
        logic             w_fit;

        if (gi == 0) begin : g_first
            assign w_rem_in = i_num[Q_W+DEN_W-1:Q_W];
            assign w_low_in = i_num[Q_W-1:0];
            assign w_quo_in = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[gi-1];
            assign w_low_in = r_low[gi-1];
            assign w_quo_in = r_quo[gi-1];
            assign w_den_in = r_den[gi-1];
        end

        assign w_trial = {w_rem_in, w_low_in[Q_W-1]};
        assign w_fit   = w_trial >= {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi] <= w_fit ? DEN_W'(w_trial - {1'b0, w_den_in}) : w_trial[DEN_W-1:0];
                r_low[gi] <= w_low_in << 1;
                r_quo[gi] <= {w_quo_in[Q_W-2:0], w_fit};
                r_den[gi] <= w_den_in;
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

`default_nettype wire
